FILE: hw/rtl/packet_bitrate_binner_assert.svh
// assertion macros used by the port level checker
`ifndef PACKET_BITRATE_BINNER_ASSERT_SVH
`define PACKET_BITRATE_BINNER_ASSERT_SVH

// implication into the next cycle, quiet while reset is high
`define PBB_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("pbb check failed");

// what must hold in the cycle after a reset cycle
`define PBB_ASSERT_AFTER_RST(name, post) \
  name: assert property (@(posedge clk) rst |=> (post)) \
    else $error("pbb reset check failed");

`endif

FILE: hw/rtl/pbb_pkg.sv
// ----------------------------------------------------------------------------
// pbb_pkg
// types, constants and the byte count function of the bitrate binner
// ----------------------------------------------------------------------------
`default_nettype none

package pbb_pkg;

  localparam int MAX_RESULTS = 64;

  localparam logic [1:0] LVL_FRAME     = 2'd0;
  localparam logic [1:0] LVL_NO_ETH    = 2'd1;
  localparam logic [1:0] LVL_IP_DATA   = 2'd2;

  localparam logic [15:0] ETYPE_IP     = 16'h0800;
  localparam logic [15:0] ETYPE_VLAN   = 16'h8100;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic signed [17:0] ETH_HDR_BYTES = 18'sd14;
  localparam logic signed [17:0] UDP_HDR_BYTES = 18'sd8;

  localparam logic [62:0] MAX63 = {63{1'b1}};
  localparam logic [39:0] MAX40 = {40{1'b1}};

  localparam logic [1:0] REG_LEVEL    = 2'd0;
  localparam logic [1:0] REG_INTERVAL = 2'd1;
  localparam logic [1:0] REG_BIT_TIME = 2'd2;
  localparam logic [1:0] REG_SAMPLE   = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FIRST,
    OP_CLOSE,
    OP_JUMP_T,
    OP_CLAMP,
    OP_LADD,
    OP_JUMP_P,
    OP_SETPREV,
    OP_TADD,
    OP_FLUSH
  } dp_op_t;

  typedef enum logic [2:0] {
    DIV_T_WB,
    DIV_E,
    DIV_PEND_WB,
    DIV_PREV,
    DIV_TOTAL
  } div_sel_t;

  typedef struct packed {
    dp_op_t   op;
    logic     div_start;
    div_sel_t div_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic started;
    logic t_ge_we;
    logic bytes_nz;
    logic loop_ok;
    logic pend_ge_we;
    logic div_done;
    logic close_ok;
  } dp_status_t;

  function automatic logic [15:0] byte_count(
    input logic [1:0]  level,
    input logic [15:0] frame,
    input logic [15:0] etype,
    input logic [15:0] iplen,
    input logic [3:0]  ihw,
    input logic [7:0]  proto,
    input logic [3:0]  tdo,
    input logic [15:0] udp
  );
    logic signed [17:0] n;
    logic signed [17:0] ihl4;
    logic signed [17:0] tdo4;
    logic signed [17:0] fr;
    logic signed [17:0] ipl;
    logic signed [17:0] ul;
    n    = '0;
    ihl4 = {12'd0, ihw, 2'b00};
    tdo4 = {12'd0, tdo, 2'b00};
    fr   = {2'b00, frame};
    ipl  = {2'b00, iplen};
    ul   = {2'b00, udp};
    case (level)
      LVL_FRAME:  n = fr;
      LVL_NO_ETH: n = fr - ETH_HDR_BYTES;
      default: begin
        if (etype == ETYPE_IP || etype == ETYPE_VLAN) begin
          if (level == LVL_IP_DATA) begin
            n = ipl - ihl4;
          end else if (proto == PROTO_TCP) begin
            n = ipl - tdo4 - ihl4;
          end else if (proto == PROTO_UDP) begin
            n = ul - UDP_HDR_BYTES;
          end
        end
      end
    endcase
    return n[17] ? 16'd0 : n[15:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pbb_div.sv
// ----------------------------------------------------------------------------
// pbb_div
// radix-2 restoring divider, 64-bit dividend by 44-bit divisor, 64 steps
// ----------------------------------------------------------------------------
`default_nettype none

module pbb_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [43:0] divisor,
  output logic [63:0]      quotient,
  output logic [43:0]      remainder,
  output logic             done
);

  logic        busy;
  logic [5:0]  cnt;
  logic [43:0] dvs;
  logic [44:0] rem_sh;
  logic [44:0] rem_sub;
  logic        ge;

  assign rem_sh  = {remainder, quotient[63]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign ge      = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 6'd0);
      if (start) begin
        busy      <= 1'b1;
        cnt       <= 6'd63;
        quotient  <= dividend;
        remainder <= '0;
        dvs       <= divisor;
      end else if (busy) begin
        cnt       <= cnt - 6'd1;
        if (cnt == 6'd0) busy <= 1'b0;
        quotient  <= {quotient[62:0], ge};
        remainder <= ge ? rem_sub[43:0] : rem_sh[43:0];
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pbb_dp.sv
// ----------------------------------------------------------------------------
// pbb_dp
// datapath: config registers, interval state, divider, result buffers
// ----------------------------------------------------------------------------
`default_nettype none

module pbb_dp #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [43:0]       cfg_data,
  input  wire logic [62:0]       arrival_time,
  input  wire logic [15:0]       frame_length,
  input  wire logic [15:0]       ether_type,
  input  wire logic [15:0]       ip_total_length,
  input  wire logic [3:0]        ip_header_words,
  input  wire logic [7:0]        ip_protocol,
  input  wire logic [3:0]        tcp_data_offset,
  input  wire logic [15:0]       udp_length,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output logic [62:0]            window_start,
  output logic [62:0]            window_bits,
  output logic [39:0]            bits_per_second,
  output logic                   last_of_run,
  input  wire pbb_pkg::dp_cmd_t  cmd,
  output pbb_pkg::dp_status_t    status
);

  // config
  logic [1:0]  payload_level;
  logic [43:0] interval_length;
  logic [19:0] bit_time;
  logic [6:0]  sample_frequency;
  logic [43:0] len_eff;
  logic [19:0] bt_eff;

  // packet and interval state
  logic        started;
  logic [63:0] t;
  logic [15:0] bytes;
  logic [38:0] total;
  logic [35:0] total_prod;
  logic [63:0] pend;
  logic [63:0] wb;
  logic [63:0] we;
  logic [62:0] bit_total;
  logic [63:0] prev_c;
  logic [6:0]  iter;
  logic [6:0]  count;

  // held result, waiting to learn whether it is the last one
  logic        pend_res_valid;
  logic [62:0] pend_start;
  logic [62:0] pend_bits;
  logic [39:0] pend_bps;

  // divider
  logic [63:0] div_dividend;
  logic [43:0] div_divisor;
  logic [63:0] div_q;
  logic [43:0] div_r;
  logic        div_done;

  logic [63:0] t_cl;
  logic [63:0] jump_t;
  logic [63:0] jump_p;
  logic [63:0] diff;
  logic [63:0] sum;
  logic [62:0] bit_total_add;
  logic [62:0] whole;
  logic [69:0] prod;
  logic [39:0] bps;
  logic        emit;
  logic        close_ok;
  logic        out_load;
  logic [63:0] len64;

  assign len_eff = (interval_length == '0) ? 44'd1 : interval_length;
  assign bt_eff  = (bit_time == '0) ? 20'd1 : bit_time;
  assign len64   = {20'd0, len_eff};

  always_comb begin
    case (cmd.div_sel)
      pbb_pkg::DIV_T_WB:    div_dividend = t - wb;
      pbb_pkg::DIV_E:       div_dividend = (we - t) << FRACTION_BITS;
      pbb_pkg::DIV_PEND_WB: div_dividend = pend - wb;
      pbb_pkg::DIV_PREV:    div_dividend = (wb - t) << FRACTION_BITS;
      pbb_pkg::DIV_TOTAL:   div_dividend = {25'd0, total} << FRACTION_BITS;
      default:              div_dividend = '0;
    endcase
    if (cmd.div_sel == pbb_pkg::DIV_T_WB || cmd.div_sel == pbb_pkg::DIV_PEND_WB) begin
      div_divisor = len_eff;
    end else begin
      div_divisor = {24'd0, bt_eff};
    end
  end

  pbb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_q),
    .remainder (div_r),
    .done      (div_done)
  );

  assign t_cl   = (t < wb) ? wb : t;
  assign jump_t = t - {20'd0, div_r};
  assign jump_p = pend - {20'd0, div_r};
  assign diff   = div_q - prev_c;
  assign sum    = {1'b0, bit_total} + diff;
  assign bit_total_add = (sum > {1'b0, pbb_pkg::MAX63}) ? pbb_pkg::MAX63 : sum[62:0];

  assign whole = bit_total >> FRACTION_BITS;
  assign prod  = {7'd0, whole} * {63'd0, sample_frequency};
  assign bps   = (prod > {30'd0, pbb_pkg::MAX40}) ? pbb_pkg::MAX40 : prod[39:0];

  assign emit     = (bit_total != '0) && (count < 7'(pbb_pkg::MAX_RESULTS));
  assign close_ok = !(pend_res_valid && out_valid && out_stall);
  // held result moves into the output register this cycle
  assign out_load = pend_res_valid
                  && ((cmd.op == pbb_pkg::OP_CLOSE && emit) || cmd.op == pbb_pkg::OP_FLUSH);

  assign status.started    = started;
  assign status.t_ge_we    = t >= we;
  assign status.bytes_nz   = bytes != '0;
  assign status.loop_ok    = (iter < 7'(pbb_pkg::MAX_RESULTS))
                           && (count < 7'(pbb_pkg::MAX_RESULTS)) && (pend >= we);
  assign status.pend_ge_we = pend >= we;
  assign status.div_done   = div_done;
  assign status.close_ok   = close_ok;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_level    <= '0;
      interval_length  <= 44'd1000000000000;
      bit_time         <= 20'd10000;
      sample_frequency <= 7'd1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pbb_pkg::REG_LEVEL:    payload_level    <= cfg_data[1:0];
        pbb_pkg::REG_INTERVAL: interval_length  <= cfg_data;
        pbb_pkg::REG_BIT_TIME: bit_time         <= cfg_data[19:0];
        pbb_pkg::REG_SAMPLE:   sample_frequency <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // transfer size, stable through the item
  assign total_prod = {20'd0, bytes} * {16'd0, bt_eff};

  always_ff @(posedge clk) begin
    total <= {total_prod, 3'b000};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started        <= 1'b0;
      wb             <= '0;
      we             <= '0;
      bit_total      <= '0;
      pend_res_valid <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (!out_load && out_valid && !out_stall) out_valid <= 1'b0;
      case (cmd.op)
        pbb_pkg::OP_LOAD: begin
          t     <= {1'b0, arrival_time};
          bytes <= pbb_pkg::byte_count(payload_level, frame_length, ether_type,
                     ip_total_length, ip_header_words, ip_protocol,
                     tcp_data_offset, udp_length);
          count <= '0;
        end
        pbb_pkg::OP_FIRST: begin
          started   <= 1'b1;
          wb        <= t;
          we        <= t + len64;
          bit_total <= '0;
        end
        pbb_pkg::OP_CLOSE: begin
          if (emit) begin
            if (pend_res_valid) begin
              out_valid       <= 1'b1;
              window_start    <= pend_start;
              window_bits     <= pend_bits;
              bits_per_second <= pend_bps;
              last_of_run     <= 1'b0;
            end
            pend_res_valid <= 1'b1;
            pend_start     <= wb[62:0];
            pend_bits      <= bit_total;
            pend_bps       <= bps;
            count          <= count + 7'd1;
          end
          wb        <= we;
          we        <= we + len64;
          bit_total <= '0;
        end
        pbb_pkg::OP_JUMP_T: begin
          wb        <= jump_t;
          we        <= jump_t + len64;
          bit_total <= '0;
        end
        pbb_pkg::OP_CLAMP: begin
          t      <= t_cl;
          pend   <= t_cl + {25'd0, total};
          prev_c <= '0;
          iter   <= '0;
        end
        pbb_pkg::OP_LADD: begin
          bit_total <= bit_total_add;
          prev_c    <= div_q;
          iter      <= iter + 7'd1;
        end
        pbb_pkg::OP_JUMP_P: begin
          wb        <= jump_p;
          we        <= jump_p + len64;
          bit_total <= '0;
        end
        pbb_pkg::OP_SETPREV: begin
          prev_c <= div_q;
        end
        pbb_pkg::OP_TADD: begin
          bit_total <= bit_total_add;
        end
        pbb_pkg::OP_FLUSH: begin
          if (pend_res_valid) begin
            out_valid       <= 1'b1;
            window_start    <= pend_start;
            window_bits     <= pend_bits;
            bits_per_second <= pend_bps;
            last_of_run     <= 1'b1;
          end
          pend_res_valid <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pbb_ctrl.sv
// ----------------------------------------------------------------------------
// pbb_ctrl
// sequencer for one packet: start, close, jump, spread, flush
// ----------------------------------------------------------------------------
`default_nettype none

module pbb_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output pbb_pkg::dp_cmd_t         cmd,
  input  wire pbb_pkg::dp_status_t status
);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_SCLOSE, S_SCHK, S_JDIV1, S_CLAMP, S_LOOP, S_LDIV,
    S_LCLOSE, S_AFTER, S_JDIV2, S_PSTART, S_PDIV, S_TSTART, S_TDIV, S_FIN
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    cmd.op        = pbb_pkg::OP_NONE;
    cmd.div_start = 1'b0;
    cmd.div_sel   = pbb_pkg::DIV_T_WB;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = pbb_pkg::OP_LOAD;
          state_next = S_START;
        end
      end
      S_START: begin
        if (!status.started) begin
          cmd.op     = pbb_pkg::OP_FIRST;
          state_next = S_CLAMP;
        end else if (status.t_ge_we) begin
          state_next = S_SCLOSE;
        end else begin
          state_next = S_CLAMP;
        end
      end
      S_SCLOSE: begin
        if (status.close_ok) begin
          cmd.op     = pbb_pkg::OP_CLOSE;
          state_next = S_SCHK;
        end
      end
      S_SCHK: begin
        if (status.t_ge_we) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = pbb_pkg::DIV_T_WB;
          state_next    = S_JDIV1;
        end else begin
          state_next = S_CLAMP;
        end
      end
      S_JDIV1: begin
        cmd.div_sel = pbb_pkg::DIV_T_WB;
        if (status.div_done) begin
          cmd.op     = pbb_pkg::OP_JUMP_T;
          state_next = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd.op     = pbb_pkg::OP_CLAMP;
        state_next = status.bytes_nz ? S_LOOP : S_FIN;
      end
      S_LOOP: begin
        if (status.loop_ok) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = pbb_pkg::DIV_E;
          state_next    = S_LDIV;
        end else begin
          state_next = S_AFTER;
        end
      end
      S_LDIV: begin
        if (status.div_done) begin
          cmd.op     = pbb_pkg::OP_LADD;
          state_next = S_LCLOSE;
        end
      end
      S_LCLOSE: begin
        if (status.close_ok) begin
          cmd.op     = pbb_pkg::OP_CLOSE;
          state_next = S_LOOP;
        end
      end
      S_AFTER: begin
        cmd.div_start = 1'b1;
        if (status.pend_ge_we) begin
          cmd.div_sel = pbb_pkg::DIV_PEND_WB;
          state_next  = S_JDIV2;
        end else begin
          cmd.div_sel = pbb_pkg::DIV_TOTAL;
          state_next  = S_TDIV;
        end
      end
      S_JDIV2: begin
        if (status.div_done) begin
          cmd.op     = pbb_pkg::OP_JUMP_P;
          state_next = S_PSTART;
        end
      end
      S_PSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = pbb_pkg::DIV_PREV;
        state_next    = S_PDIV;
      end
      S_PDIV: begin
        if (status.div_done) begin
          cmd.op     = pbb_pkg::OP_SETPREV;
          state_next = S_TSTART;
        end
      end
      S_TSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = pbb_pkg::DIV_TOTAL;
        state_next    = S_TDIV;
      end
      S_TDIV: begin
        if (status.div_done) begin
          cmd.op     = pbb_pkg::OP_TADD;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (status.close_ok) begin
          cmd.op     = pbb_pkg::OP_FLUSH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/packet_bitrate_binner.sv
// ----------------------------------------------------------------------------
// packet_bitrate_binner
// spreads captured packets over sampling intervals and reports bits per interval
// ----------------------------------------------------------------------------
// One packet beat goes in at a time; in_stall stays high until every result it
// causes has been handed to the output register or the held-result buffer. The
// cost is set by a shared radix-2 divider that the sequencer waits on for
// each division: a packet that closes no interval needs none with zero bytes,
// else one; each interval it closes in the spread loop costs one division
// more, and an interval jump adds one or two divisions. A closed
// interval's result is held back one step so the final one of the packet can
// carry last_of_run; output back-pressure only stalls the sequencer when both
// the held result and the output register are full.
`default_nettype none

module packet_bitrate_binner #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // config write port
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [43:0] cfg_data,
  // packet beats
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [62:0] arrival_time,
  input  wire logic [15:0] frame_length,
  input  wire logic [15:0] ether_type,
  input  wire logic [15:0] ip_total_length,
  input  wire logic [3:0]  ip_header_words,
  input  wire logic [7:0]  ip_protocol,
  input  wire logic [3:0]  tcp_data_offset,
  input  wire logic [15:0] udp_length,
  // result beats
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [62:0]      window_start,
  output logic [62:0]      window_bits,
  output logic [39:0]      bits_per_second,
  output logic             last_of_run
);

  pbb_pkg::dp_cmd_t    cmd;
  pbb_pkg::dp_status_t status;

  // sequencer for one packet beat
  pbb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  // interval state, divider and result registers
  pbb_dp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .arrival_time    (arrival_time),
    .frame_length    (frame_length),
    .ether_type      (ether_type),
    .ip_total_length (ip_total_length),
    .ip_header_words (ip_header_words),
    .ip_protocol     (ip_protocol),
    .tcp_data_offset (tcp_data_offset),
    .udp_length      (udp_length),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .window_start    (window_start),
    .window_bits     (window_bits),
    .bits_per_second (bits_per_second),
    .last_of_run     (last_of_run),
    .cmd             (cmd),
    .status          (status)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/pbb_checker.sv
// ----------------------------------------------------------------------------
// pbb_checker
// port level checks on the bitrate binner, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "packet_bitrate_binner_assert.svh"

module pbb_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall
);

  // a taken packet beat keeps the input closed for the next cycle
  `PBB_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // a stalled result stays offered
  `PBB_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid)

  // no result straight out of reset
  `PBB_ASSERT_AFTER_RST(a_rst_quiet, !out_valid && !in_stall)

endmodule

bind packet_bitrate_binner pbb_checker u_pbb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

`default_nettype wire
